>>> rtl/apd_pkg.sv
// ----------------------------------------------------------------------------
// apd_pkg
// Shared types and constants for the addressed program download controller.
// ----------------------------------------------------------------------------
package apd_pkg;

  // Default size of the program buffer, in bytes.
  localparam int BUFFER_DEPTH_DEFAULT = 64;

  // Command codes carried with each input request.
  localparam logic [1:0] CMD_RX    = 2'd0;
  localparam logic [1:0] CMD_FAULT = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_COMMIT = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;
  localparam logic [1:0] KIND_READ   = 2'd3;

  // Download phase codes.
  localparam logic [2:0] PH_EMPTY   = 3'd0;
  localparam logic [2:0] PH_START   = 3'd1;
  localparam logic [2:0] PH_RESTART = 3'd2;
  localparam logic [2:0] PH_LOADING = 3'd3;
  localparam logic [2:0] PH_READY   = 3'd4;

  // Protocol bytes and status encoding.
  localparam logic [7:0]        BYTE_START  = 8'h7F;
  localparam logic [7:0]        BYTE_END    = 8'h7E;
  localparam logic signed [11:0] STATUS_BIAS = 12'sd1000;
  localparam logic [7:0]        READY_FLAG  = 8'h01;

  // Number of bytes in a status reply.
  localparam logic [2:0] STATUS_COUNT = 3'd5;

  // Result descriptor handed from the controller to the output stage.
  typedef struct packed {
    logic       load;   // a result group enters the output register
    logic [1:0] kind;   // kind of every result in the group
    logic [2:0] count;  // number of results in the group, 1 to 5
    logic       ready;  // program ready flag for the status reply
  } res_t;

endpackage

>>> rtl/apd_ctrl.sv
// ----------------------------------------------------------------------------
// apd_ctrl
// Input register, download phase machine, write position and program buffer.
// Each request is decoded combinationally from the input register.
// ----------------------------------------------------------------------------
module apd_ctrl #(
  parameter int BUFFER_DEPTH = apd_pkg::BUFFER_DEPTH_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [1:0]                            command,
  input  logic [7:0]                            rx_byte,
  input  logic [5:0]                            read_index,
  input  logic signed [10:0]                    acc_value,
  input  logic signed [10:0]                    dat_value,
  input  logic [7:0]                            own_address,
  input  logic                                  load_ok,
  output apd_pkg::res_t                         res,
  output logic [11:0]                           acc_sum,
  output logic [11:0]                           dat_sum,
  output logic [$clog2(BUFFER_DEPTH+1)-1:0]     res_len,
  output logic [7:0]                            rd_data
);

  localparam int LW = $clog2(BUFFER_DEPTH + 1);
  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int XW = (LW > 6) ? LW : 6;

  // Input register.
  logic               s1_valid;
  logic [1:0]         s1_command;
  logic [7:0]         s1_rx;
  logic [5:0]         s1_index;
  logic signed [10:0] s1_acc;
  logic signed [10:0] s1_dat;

  // Control state.
  logic [2:0]    phase;
  logic [2:0]    phase_next;
  logic [LW-1:0] write_position;
  logic [LW-1:0] write_position_next;

  // Program buffer.
  logic [7:0] program_store [BUFFER_DEPTH];

  logic          fire;
  logic          wr_en;
  logic          rd_en;
  logic [2:0]    count;
  logic [1:0]    kind;
  logic [LW-1:0] len;
  logic [XW-1:0] rd_ext;
  logic          rd_in_range;
  logic          addr_hit;

  // The request retires when it has no results or the output register is free.
  assign fire     = s1_valid && ((count == 3'd0) || load_ok);
  assign in_ready = !s1_valid || fire;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_command <= command;
      s1_rx      <= rx_byte;
      s1_index   <= read_index;
      s1_acc     <= acc_value;
      s1_dat     <= dat_value;
    end
  end

  assign addr_hit = (s1_rx == own_address);

  // Request decode and next state.
  always_comb begin
    phase_next          = phase;
    write_position_next = write_position;
    count               = 3'd0;
    kind                = apd_pkg::KIND_STATUS;
    len                 = '0;
    wr_en               = 1'b0;
    rd_en               = 1'b0;
    unique case (s1_command)
      apd_pkg::CMD_RX: begin
        if ((phase == apd_pkg::PH_READY || phase == apd_pkg::PH_EMPTY) && addr_hit) begin
          count = apd_pkg::STATUS_COUNT;
        end else if (phase == apd_pkg::PH_START || phase == apd_pkg::PH_RESTART) begin
          write_position_next = '0;
          if (addr_hit) begin
            count      = 3'd1;
            kind       = apd_pkg::KIND_CLEAR;
            phase_next = apd_pkg::PH_LOADING;
          end else if (phase == apd_pkg::PH_START) begin
            count      = 3'd1;
            kind       = apd_pkg::KIND_CLEAR;
            phase_next = apd_pkg::PH_EMPTY;
          end else begin
            phase_next = apd_pkg::PH_READY;
          end
        end else if (phase == apd_pkg::PH_LOADING) begin
          if (s1_rx == apd_pkg::BYTE_END) begin
            count = 3'd1;
            if (write_position > LW'(2)) begin
              kind       = apd_pkg::KIND_COMMIT;
              len        = write_position;
              phase_next = apd_pkg::PH_READY;
            end else begin
              kind                = apd_pkg::KIND_CLEAR;
              write_position_next = '0;
              phase_next          = apd_pkg::PH_EMPTY;
            end
          end else if (write_position < LW'(BUFFER_DEPTH)) begin
            wr_en               = 1'b1;
            write_position_next = write_position + LW'(1);
          end
        end else if (s1_rx == apd_pkg::BYTE_START) begin
          phase_next = (phase == apd_pkg::PH_READY) ? apd_pkg::PH_RESTART
                                                    : apd_pkg::PH_START;
        end
      end
      apd_pkg::CMD_FAULT: begin
        if (phase == apd_pkg::PH_READY) begin
          count               = 3'd1;
          kind                = apd_pkg::KIND_CLEAR;
          write_position_next = '0;
          phase_next          = apd_pkg::PH_EMPTY;
        end
      end
      apd_pkg::CMD_READ: begin
        count = 3'd1;
        kind  = apd_pkg::KIND_READ;
        rd_en = 1'b1;
      end
      default: begin
        count = 3'd0;
      end
    endcase
  end

  // Control state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= apd_pkg::PH_EMPTY;
      write_position <= '0;
    end else if (fire) begin
      phase          <= phase_next;
      write_position <= write_position_next;
    end
  end

  // Program buffer write and registered read; positions past the end read zero.
  assign rd_ext      = XW'(s1_index);
  assign rd_in_range = (rd_ext < XW'(BUFFER_DEPTH));

  always_ff @(posedge clk) begin
    if (fire && wr_en) begin
      program_store[write_position[AW-1:0]] <= s1_rx;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && rd_en) begin
      rd_data <= rd_in_range ? program_store[rd_ext[AW-1:0]] : 8'h00;
    end
  end

  // Result descriptor for the output stage.
  assign res.load  = fire && (count != 3'd0);
  assign res.kind  = kind;
  assign res.count = count;
  assign res.ready = (phase == apd_pkg::PH_READY);
  assign res_len   = len;

  // Biased status values.
  assign acc_sum = {s1_acc[10], s1_acc} + apd_pkg::STATUS_BIAS;
  assign dat_sum = {s1_dat[10], s1_dat} + apd_pkg::STATUS_BIAS;

endmodule

>>> rtl/apd_out.sv
// ----------------------------------------------------------------------------
// apd_out
// Result register. Holds one result group and delivers it one result per
// request, sequencing the five status bytes.
// ----------------------------------------------------------------------------
module apd_out #(
  parameter int BUFFER_DEPTH = apd_pkg::BUFFER_DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  apd_pkg::res_t                     res,
  input  logic [11:0]                       acc_sum,
  input  logic [11:0]                       dat_sum,
  input  logic [$clog2(BUFFER_DEPTH+1)-1:0] res_len,
  input  logic [7:0]                        rd_data,
  output logic                              load_ok,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_kind,
  output logic [7:0]                        out_byte,
  output logic [$clog2(BUFFER_DEPTH+1)-1:0] program_length,
  output logic                              last
);

  localparam int LW = $clog2(BUFFER_DEPTH + 1);

  logic          r_valid;
  logic [1:0]    r_kind;
  logic [2:0]    r_count;
  logic [2:0]    r_idx;
  logic          r_ready;
  logic [11:0]   r_acc;
  logic [11:0]   r_dat;
  logic [LW-1:0] r_len;
  logic [7:0]    status_byte;

  assign last    = (r_idx == (r_count - 3'd1));
  assign load_ok = !r_valid || (out_ready && last);

  // Group valid and position within the group.
  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
      r_idx   <= 3'd0;
    end else if (load_ok) begin
      r_valid <= res.load;
      r_idx   <= 3'd0;
    end else if (out_ready) begin
      r_idx <= r_idx + 3'd1;
    end
  end

  // Group payload.
  always_ff @(posedge clk) begin
    if (load_ok && res.load) begin
      r_kind  <= res.kind;
      r_count <= res.count;
      r_ready <= res.ready;
      r_acc   <= acc_sum;
      r_dat   <= dat_sum;
      r_len   <= res_len;
    end
  end

  // Status byte selection: high and low parts of each biased value, then flag.
  always_comb begin
    unique case (r_idx)
      3'd0:    status_byte = {{3{r_acc[11]}}, r_acc[11:7]};
      3'd1:    status_byte = {1'b0, r_acc[6:0]};
      3'd2:    status_byte = {{3{r_dat[11]}}, r_dat[11:7]};
      3'd3:    status_byte = {1'b0, r_dat[6:0]};
      default: status_byte = r_ready ? apd_pkg::READY_FLAG : 8'h00;
    endcase
  end

  // Output fields.
  always_comb begin
    unique case (r_kind)
      apd_pkg::KIND_STATUS: out_byte = status_byte;
      apd_pkg::KIND_READ:   out_byte = rd_data;
      default:              out_byte = 8'h00;
    endcase
  end

  assign out_valid      = r_valid;
  assign out_kind       = r_kind;
  assign program_length = (r_kind == apd_pkg::KIND_COMMIT) ? r_len : '0;

endmodule

>>> rtl/addressed_program_download_fsm.sv
// ----------------------------------------------------------------------------
// addressed_program_download_fsm
// Serial download controller for an addressed node: status replies, program
// download into a local buffer, commit or clear, and buffer readback.
//
//   channel   direction  handshake              payload
//   in        sink       in_valid / in_ready    command, rx_byte, read_index,
//                                               acc_value, dat_value
//   out       source     out_valid / out_ready  out_kind, out_byte,
//                                               program_length, last
//   cfg       sink       cfg_valid / cfg_ready  cfg_data (own address)
//
// One request is accepted per cycle unless the result register stalls; it is
// decoded from the input register and its results then enter the result register.
// A status reply holds the result register for five output bytes; other
// requests give at most one result. Requests with no result retire at once.
// While the result register is stalled, one further request waits in the
// input register. Reset clears control state only; the program buffer is
// undefined until written and needs no clearing pass.
// ----------------------------------------------------------------------------
module addressed_program_download_fsm #(
  parameter int BUFFER_DEPTH = apd_pkg::BUFFER_DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        command,
  input  logic [7:0]                        rx_byte,
  input  logic [5:0]                        read_index,
  input  logic signed [10:0]                acc_value,
  input  logic signed [10:0]                dat_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_kind,
  output logic [7:0]                        out_byte,
  output logic [$clog2(BUFFER_DEPTH+1)-1:0] program_length,
  output logic                              last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [7:0]                        cfg_data
);

  localparam int LW = $clog2(BUFFER_DEPTH + 1);

  logic [7:0]    own_address;
  apd_pkg::res_t res;
  logic          load_ok;
  logic [11:0]   acc_sum;
  logic [11:0]   dat_sum;
  logic [LW-1:0] res_len;
  logic [7:0]    rd_data;

  // Address register; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address <= 8'h00;
    end else if (cfg_valid && cfg_ready) begin
      own_address <= cfg_data;
    end
  end

  // Decode, phase machine and program buffer.
  apd_ctrl #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .rx_byte     (rx_byte),
    .read_index  (read_index),
    .acc_value   (acc_value),
    .dat_value   (dat_value),
    .own_address (own_address),
    .load_ok     (load_ok),
    .res         (res),
    .acc_sum     (acc_sum),
    .dat_sum     (dat_sum),
    .res_len     (res_len),
    .rd_data     (rd_data)
  );

  // Result register and status sequencing.
  apd_out #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_out (
    .clk            (clk),
    .rst            (rst),
    .res            (res),
    .acc_sum        (acc_sum),
    .dat_sum        (dat_sum),
    .res_len        (res_len),
    .rd_data        (rd_data),
    .load_ok        (load_ok),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_byte       (out_byte),
    .program_length (program_length),
    .last           (last)
  );

  // A result group only enters a free result register.
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    res.load |-> load_ok)
    else $error("result group loaded while the result register was busy");

  // Everything but a status reply is a single result.
  a_single: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind != apd_pkg::KIND_STATUS) |-> last)
    else $error("non-status result not marked last");

  // A length is only reported with a commit.
  a_len_commit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind != apd_pkg::KIND_COMMIT) |-> (program_length == '0))
    else $error("program length reported outside a commit");

  // A status reply that is not finished keeps going with status bytes.
  a_status_run: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && out_kind == apd_pkg::KIND_STATUS && !last)
      |=> (out_valid && out_kind == apd_pkg::KIND_STATUS))
    else $error("status reply interrupted");

endmodule

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the addressed program download controller. A
// directed table walks status replies, download start, cancel, commit, clear,
// fault and buffer readback. Random request streams then run under several
// node addresses. Every accepted request goes through an in-bench model of
// the node, and the replies it predicts are compared in order with the
// output channel.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = apd_pkg::BUFFER_DEPTH_DEFAULT;
  localparam int LW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 6;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_PER_PHASE = 48;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  rx;
    logic [5:0]  idx;
    logic [10:0] acc;
    logic [10:0] dat;
  } request_t;

  typedef struct packed {
    logic [1:0]    kind;
    logic [7:0]    data;
    logic [LW-1:0] len;
    logic          fin;
  } reply_t;

  typedef struct packed {
    request_t req;
    logic     hand;        // first reply is typed in by hand
    reply_t   hand_reply;
  } table_row_t;

  typedef enum {RDY_ALWAYS, RDY_HALF, RDY_SPARSE, RDY_STALLS} ready_mode_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           command = apd_pkg::CMD_RX;
  logic [7:0]           rx_byte = 8'h00;
  logic [5:0]           read_index = 6'd0;
  logic signed [10:0]   acc_value = 11'sd0;
  logic signed [10:0]   dat_value = 11'sd0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [1:0]           out_kind;
  logic [7:0]           out_byte;
  logic [LW-1:0]        program_length;
  logic                 last;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [7:0]           cfg_data = 8'h00;

  // Model of the node: phase, fill pointer, committed length, buffer.
  logic [2:0]    node_phase = apd_pkg::PH_EMPTY;
  logic [LW-1:0] fill_pos = '0;
  logic [LW-1:0] prog_len = '0;
  logic [7:0]    node_addr = 8'h00;
  logic [7:0]    prog_mem [DEPTH];
  int            stored_hi = 0;   // entries 0 .. stored_hi-1 have been written

  reply_t        reply_q[$];
  table_row_t    dir_rows[$];
  int            err_count = 0;
  int            burst_left = 0;

  addressed_program_download_fsm dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .command        (command),
    .rx_byte        (rx_byte),
    .read_index     (read_index),
    .acc_value      (acc_value),
    .dat_value      (dat_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_byte       (out_byte),
    .program_length (program_length),
    .last           (last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Print one line per mismatch and count it.
  task automatic report_error(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    err_count++;
  endtask

  function automatic void push_reply(input logic [1:0] kind, input logic [7:0] data,
                                     input logic [LW-1:0] len);
    reply_q.push_back('{kind: kind, data: data, len: len, fin: 1'b0});
  endfunction

  function automatic void clear_program();
    fill_pos = '0;
    prog_len = '0;
    node_phase = apd_pkg::PH_EMPTY;
    push_reply(apd_pkg::KIND_CLEAR, 8'h00, '0);
  endfunction

  // Status encoding: the register value is biased to be non-negative, then
  // split into the bits above seven and the low seven bits.
  function automatic logic [7:0] status_high(input logic [10:0] v);
    int sum;
    sum = $signed(v) + apd_pkg::STATUS_BIAS;
    sum = sum >>> 7;
    return sum[7:0];
  endfunction

  function automatic logic [7:0] status_low(input logic [10:0] v);
    int sum;
    sum = $signed(v) + apd_pkg::STATUS_BIAS;
    return {1'b0, sum[6:0]};
  endfunction

  // Advance the node model by one request and queue the replies it gives.
  function automatic void predict_replies(input request_t r);
    int first;
    first = reply_q.size();
    unique case (r.cmd)
      apd_pkg::CMD_RX: begin
        if ((node_phase == apd_pkg::PH_READY || node_phase == apd_pkg::PH_EMPTY) &&
            r.rx == node_addr) begin
          push_reply(apd_pkg::KIND_STATUS, status_high(r.acc), '0);
          push_reply(apd_pkg::KIND_STATUS, status_low(r.acc), '0);
          push_reply(apd_pkg::KIND_STATUS, status_high(r.dat), '0);
          push_reply(apd_pkg::KIND_STATUS, status_low(r.dat), '0);
          push_reply(apd_pkg::KIND_STATUS,
                     (node_phase == apd_pkg::PH_READY) ? apd_pkg::READY_FLAG : 8'h00, '0);
        end else if (node_phase == apd_pkg::PH_START || node_phase == apd_pkg::PH_RESTART) begin
          if (r.rx == node_addr) begin
            clear_program();
            node_phase = apd_pkg::PH_LOADING;
          end else if (node_phase == apd_pkg::PH_START) begin
            clear_program();
          end else begin
            // A cancelled restart keeps the committed program.
            fill_pos = '0;
            node_phase = apd_pkg::PH_READY;
          end
        end else if (node_phase == apd_pkg::PH_LOADING) begin
          if (r.rx == apd_pkg::BYTE_END) begin
            if (fill_pos > 2) begin
              node_phase = apd_pkg::PH_READY;
              prog_len = fill_pos;
              push_reply(apd_pkg::KIND_COMMIT, 8'h00, prog_len);
            end else begin
              clear_program();
            end
          end else if (fill_pos < DEPTH) begin
            // Bytes past a full buffer are dropped.
            prog_mem[fill_pos[AW-1:0]] = r.rx;
            fill_pos++;
            if (fill_pos > stored_hi) stored_hi = int'(fill_pos);
          end
        end else if (r.rx == apd_pkg::BYTE_START) begin
          node_phase = (node_phase == apd_pkg::PH_READY) ? apd_pkg::PH_RESTART
                                                         : apd_pkg::PH_START;
        end
      end
      apd_pkg::CMD_FAULT: begin
        if (node_phase == apd_pkg::PH_READY) clear_program();
      end
      apd_pkg::CMD_READ: begin
        push_reply(apd_pkg::KIND_READ, prog_mem[r.idx], '0);
      end
      default: ;
    endcase
    if (reply_q.size() > first) reply_q[reply_q.size() - 1].fin = 1'b1;
  endfunction

  // Present one request, hold it until accepted, then predict its replies.
  // The sender runs in bursts with random gaps in between.
  task automatic drive_request(input request_t r, input logic hand, input reply_t hand_reply);
    int first;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    command <= r.cmd;
    rx_byte <= r.rx;
    read_index <= r.idx;
    acc_value <= r.acc;
    dat_value <= r.dat;
    do @(posedge clk); while (!in_ready);
    first = reply_q.size();
    predict_replies(r);
    if (hand && reply_q.size() > first) reply_q[first] = hand_reply;
  endtask

  // Write the node address once the block has gone quiet.
  task automatic set_node_address(input logic [7:0] addr);
    in_valid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= addr;
    do @(posedge clk); while (!cfg_ready);
    node_addr = addr;
    cfg_valid <= 1'b0;
    burst_left = 0;
  endtask

  function automatic void add_row(input logic [1:0] cmd, input logic [7:0] rx,
                                  input int idx, input int acc, input int dat,
                                  input bit hand = 1'b0,
                                  input logic [1:0] kind = apd_pkg::KIND_STATUS,
                                  input logic [7:0] data = 8'h00,
                                  input int len = 0, input bit fin = 1'b0);
    table_row_t row;
    row.req = '{cmd: cmd, rx: rx, idx: 6'(idx), acc: 11'(acc), dat: 11'(dat)};
    row.hand = hand;
    row.hand_reply = '{kind: kind, data: data, len: LW'(len), fin: fin};
    dir_rows.push_back(row);
  endfunction

  // Register values are mostly in the legal range, sometimes any 11-bit code.
  function automatic logic [10:0] rand_register();
    if ($urandom_range(0, 9) == 0) return 11'($urandom);
    return 11'($urandom_range(0, 1998) - 999);
  endfunction

  function automatic request_t rand_request(input logic [1:0] cmd, input logic [7:0] rx);
    request_t r;
    r.cmd = cmd;
    r.rx = rx;
    r.idx = 6'($urandom_range(0, 63));
    r.acc = rand_register();
    r.dat = rand_register();
    return r;
  endfunction

  task automatic send_request(input logic [1:0] cmd, input logic [7:0] rx);
    drive_request(rand_request(cmd, rx), 1'b0, '0);
  endtask

  // Reads only touch buffer entries that a download has written.
  task automatic send_read();
    request_t r;
    r = rand_request(apd_pkg::CMD_READ, 8'($urandom));
    if ($urandom_range(0, 3) == 0) r.idx = 6'(stored_hi - 1);
    else r.idx = 6'($urandom_range(0, stored_hi - 1));
    drive_request(r, 1'b0, '0);
  endtask

  // Random traffic: mostly well-formed status queries and downloads with
  // random content, plus cancelled starts, faults, reads and stray bytes.
  task automatic run_random(input int quota, input bit long_owed);
    int sent;
    int pick;
    int len;
    logic [7:0] b;
    sent = 0;
    while (sent < quota) begin
      pick = $urandom_range(0, 99);
      if (pick < 22) begin
        send_request(apd_pkg::CMD_RX, node_addr);
        sent++;
      end else if (pick < 55) begin
        send_request(apd_pkg::CMD_RX, apd_pkg::BYTE_START);
        if ($urandom_range(0, 5) == 0) begin
          do b = 8'($urandom); while (b == node_addr);
          send_request(apd_pkg::CMD_RX, b);
          sent += 2;
        end else begin
          send_request(apd_pkg::CMD_RX, node_addr);
          if (long_owed) len = DEPTH + 3;
          else if ($urandom_range(0, 19) == 0) len = $urandom_range(DEPTH - 4, DEPTH + 6);
          else len = $urandom_range(0, 9);
          long_owed = 1'b0;
          repeat (len) begin
            if ($urandom_range(0, 29) == 0) send_request(apd_pkg::CMD_FAULT, 8'($urandom));
            if ($urandom_range(0, 29) == 0 && stored_hi > 0) send_read();
            do b = 8'($urandom); while (b == apd_pkg::BYTE_END);
            send_request(apd_pkg::CMD_RX, b);
          end
          send_request(apd_pkg::CMD_RX, apd_pkg::BYTE_END);
          sent += len + 3;
        end
      end else if (pick < 65) begin
        send_request(apd_pkg::CMD_FAULT, 8'($urandom));
        sent++;
      end else if (pick < 80) begin
        if (stored_hi > 0) send_read();
        else send_request(apd_pkg::CMD_RX, node_addr);
        sent++;
      end else if (pick < 90) begin
        send_request(apd_pkg::CMD_RX, 8'($urandom));
        sent++;
      end else if (pick < 95) begin
        send_request(CMD_UNUSED, 8'($urandom));
        sent++;
      end else begin
        // Start byte followed by any byte, address included.
        send_request(apd_pkg::CMD_RX, apd_pkg::BYTE_START);
        send_request(apd_pkg::CMD_RX, 8'($urandom));
        sent += 2;
      end
    end
  endtask

  // Receiver: ready pattern changes between always, random, sparse and
  // long stalls.
  ready_mode_t ready_mode = RDY_ALWAYS;
  int          mode_left = 0;
  int          mode_tick = 0;

  always @(posedge clk) begin
    if (mode_left == 0) begin
      ready_mode = ready_mode_t'($urandom_range(0, 3));
      mode_left = $urandom_range(20, 120);
    end
    mode_left--;
    mode_tick++;
    unique case (ready_mode)
      RDY_ALWAYS: out_ready <= 1'b1;
      RDY_HALF:   out_ready <= 1'($urandom_range(0, 1));
      RDY_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
      default:    out_ready <= (mode_tick % 12 == 0);
    endcase
  end

  // Compare every accepted reply with the oldest prediction.
  always @(posedge clk) begin : check_replies
    reply_t want;
    if (!rst && out_valid && out_ready) begin
      if (reply_q.size() == 0) begin
        report_error($sformatf("reply kind %0d byte %h with none expected",
                               out_kind, out_byte));
      end else begin
        want = reply_q.pop_front();
        if (out_kind !== want.kind)
          report_error($sformatf("kind %0d, predicted %0d", out_kind, want.kind));
        if (out_byte !== want.data)
          report_error($sformatf("byte %h, predicted %h", out_byte, want.data));
        if (program_length !== want.len)
          report_error($sformatf("length %0d, predicted %0d", program_length, want.len));
        if (last !== want.fin)
          report_error($sformatf("last %b, predicted %b", last, want.fin));
      end
    end
  end

  // Watchdog: end the run when no channel has moved for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Mismatches found");
    $finish;
  end

  // Main sequence: reset, directed table, random phases, drain.
  initial begin : main_seq
    logic [7:0] phase_addr [5];

    // Status reply from an empty node at the lowest legal accumulator.
    add_row(apd_pkg::CMD_RX, 8'h00, 0, -999, 999, 1'b1, apd_pkg::KIND_STATUS, 8'h00, 0, 1'b0);
    // Fault while empty and the unused command are both ignored.
    add_row(apd_pkg::CMD_FAULT, 8'h00, 63, 0, 0);
    add_row(CMD_UNUSED, 8'hFF, 63, 0, 0);
    // A start from empty cancelled by a foreign byte clears.
    add_row(apd_pkg::CMD_RX, apd_pkg::BYTE_START, 0, 0, 0);
    add_row(apd_pkg::CMD_RX, 8'h05, 0, 0, 0, 1'b1, apd_pkg::KIND_CLEAR, 8'h00, 0, 1'b1);
    // A download that ends right away is cleared.
    add_row(apd_pkg::CMD_RX, apd_pkg::BYTE_START, 0, 0, 0);
    add_row(apd_pkg::CMD_RX, 8'h00, 0, 0, 0, 1'b1, apd_pkg::KIND_CLEAR, 8'h00, 0, 1'b1);
    add_row(apd_pkg::CMD_RX, apd_pkg::BYTE_END, 0, 0, 0, 1'b1, apd_pkg::KIND_CLEAR, 8'h00, 0,
            1'b1);
    // Three-byte download; a start byte inside the download is plain data.
    add_row(apd_pkg::CMD_RX, apd_pkg::BYTE_START, 0, 0, 0);
    add_row(apd_pkg::CMD_RX, 8'h00, 0, 0, 0, 1'b1, apd_pkg::KIND_CLEAR, 8'h00, 0, 1'b1);
    add_row(apd_pkg::CMD_RX, 8'hFF, 0, 0, 0);
    add_row(apd_pkg::CMD_RX, 8'h00, 0, 0, 0);
    add_row(apd_pkg::CMD_RX, apd_pkg::BYTE_START, 0, 0, 0);
    add_row(apd_pkg::CMD_RX, apd_pkg::BYTE_END, 0, 0, 0, 1'b1, apd_pkg::KIND_COMMIT, 8'h00, 3,
            1'b1);
    // Status from a ready node with register values beyond the legal range.
    add_row(apd_pkg::CMD_RX, 8'h00, 0, -1024, 1023, 1'b1, apd_pkg::KIND_STATUS, 8'hFF, 0,
            1'b0);
    // Read back the first and last downloaded bytes.
    add_row(apd_pkg::CMD_READ, 8'h00, 0, 0, 0, 1'b1, apd_pkg::KIND_READ, 8'hFF, 0, 1'b1);
    add_row(apd_pkg::CMD_READ, 8'h00, 2, 0, 0, 1'b1, apd_pkg::KIND_READ, 8'h7F, 0, 1'b1);
    // A restart cancelled by a foreign byte keeps the program.
    add_row(apd_pkg::CMD_RX, apd_pkg::BYTE_START, 0, 0, 0);
    add_row(apd_pkg::CMD_RX, 8'h33, 0, 0, 0);
    // A fault clears a ready program; a second one is ignored.
    add_row(apd_pkg::CMD_FAULT, 8'h00, 0, 0, 0, 1'b1, apd_pkg::KIND_CLEAR, 8'h00, 0, 1'b1);
    add_row(apd_pkg::CMD_FAULT, 8'h00, 0, 0, 0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i])
      drive_request(dir_rows[i].req, dir_rows[i].hand, dir_rows[i].hand_reply);

    // Address extremes, the two protocol bytes and one random address.
    phase_addr = '{8'hFF, apd_pkg::BYTE_END, 8'($urandom_range(0, 255)), apd_pkg::BYTE_START,
                   8'h00};
    foreach (phase_addr[p]) begin
      set_node_address(phase_addr[p]);
      run_random(RANDOM_PER_PHASE, p == 0);
    end

    in_valid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
